FILE: sv/assembly_source_tokenizer_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the assembly source tokenizer
// ---------------------------------------------------------------------------
`ifndef ASSEMBLY_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AST_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define AST_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

FILE: sv/ast_pkg.sv
// ---------------------------------------------------------------------------
// Tokenizer package
// Token kinds, lexer modes, number bases and error codes.
// ---------------------------------------------------------------------------
package ast_pkg;

    localparam int unsigned VALUE_BITS = 63;
    localparam int unsigned KIND_BITS  = 5;
    localparam int unsigned ERR_BITS   = 2;
    localparam int unsigned MAX_RES    = 3;

    localparam logic [4:0] K_INT     = 5'd0;
    localparam logic [4:0] K_STRING  = 5'd1;
    localparam logic [4:0] K_IDENT   = 5'd2;
    localparam logic [4:0] K_LPAREN  = 5'd3;
    localparam logic [4:0] K_RPAREN  = 5'd4;
    localparam logic [4:0] K_LBRACK  = 5'd5;
    localparam logic [4:0] K_RBRACK  = 5'd6;
    localparam logic [4:0] K_COLON   = 5'd7;
    localparam logic [4:0] K_COMMA   = 5'd8;
    localparam logic [4:0] K_NEWLINE = 5'd9;
    localparam logic [4:0] K_EOF     = 5'd10;
    localparam logic [4:0] K_TIMES   = 5'd11;
    localparam logic [4:0] K_PLUS    = 5'd12;
    localparam logic [4:0] K_MINUS   = 5'd13;
    localparam logic [4:0] K_STAR    = 5'd14;
    localparam logic [4:0] K_DIV     = 5'd15;
    localparam logic [4:0] K_PERCENT = 5'd16;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNEXPECT = 2'd1;
    localparam logic [1:0] E_UNTERM   = 2'd2;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_ZERO    = 4'd2;
    localparam logic [3:0] M_NUMBER  = 4'd3;
    localparam logic [3:0] M_IDENT   = 4'd4;
    localparam logic [3:0] M_STRING  = 4'd5;
    localparam logic [3:0] M_ESCAPE  = 4'd6;
    localparam logic [3:0] M_ESC_OCT = 4'd7;
    localparam logic [3:0] M_ESC_HEX = 4'd8;
    localparam logic [3:0] M_COMMENT = 4'd9;

    localparam logic [1:0] B_BIN = 2'd0;
    localparam logic [1:0] B_OCT = 2'd1;
    localparam logic [1:0] B_DEC = 2'd2;
    localparam logic [1:0] B_HEX = 2'd3;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [4:0]            token_kind;
        logic                  is_text_byte;
        logic [VALUE_BITS-1:0] token_value;
        logic [15:0]           line_number;
        logic [11:0]           column_number;
        logic [1:0]            error_code;
        logic                  last;
    } t_token;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text;

    function automatic logic [7:0] f_times_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h74;
            3'd1:    return 8'h69;
            3'd2:    return 8'h6d;
            3'd3:    return 8'h65;
            3'd4:    return 8'h73;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_escape_named(input logic [7:0] b);
        case (b)
            8'h61:   return 8'd7;
            8'h62:   return 8'd8;
            8'h65:   return 8'd27;
            8'h66:   return 8'd12;
            8'h6e:   return 8'd10;
            8'h72:   return 8'd13;
            8'h74:   return 8'd9;
            8'h76:   return 8'd11;
            default: return b;
        endcase
    endfunction

    // Hex digit value; bit 4 set when the byte is not a hex digit.
    function automatic logic [4:0] f_hex(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
        return 5'h10;
    endfunction

endpackage

FILE: sv/ast_stream_if.sv
// ---------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one beat of a generic payload between a source and a sink.
// ---------------------------------------------------------------------------
interface ast_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/assembly_source_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// Assembly source tokenizer
// Lexes source text one byte per beat into integer, string, identifier,
// keyword, punctuation, newline and end-of-file tokens.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  i_text    sink       text_byte, end_of_text
//  o_token   source     token_kind .. last (up to three beats per input)
//
// A byte is lexed in the cycle it is accepted; its results go into a queue
// of three result registers. One token beat leaves per cycle while o_token
// is ready, so a byte that makes one result or none then sustains one byte
// per cycle, and a byte making more results holds the input. Input is taken
// whenever the queue is empty or drains to empty on that edge. Reset is
// synchronous, active low, and returns the lexer to line 0, column 0.
`include "assembly_source_tokenizer_unit_macros.svh"

module assembly_source_tokenizer_unit #(
    parameter int unsigned LINE_BITS   = 16,
    parameter int unsigned COLUMN_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ast_stream_if.sink           i_text,
    ast_stream_if.source         o_token
);
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_TOP  = {COLUMN_BITS{1'b1}};
    localparam int unsigned VB = ast_pkg::VALUE_BITS;

    // state
    logic [3:0]             r_mode, n_mode;
    logic [1:0]             r_base, n_base;
    logic [VB-1:0]          r_acc, n_acc;
    logic                   r_quote, n_quote;
    logic [7:0]             r_esc, n_esc;
    logic [1:0]             r_esc_cnt, n_esc_cnt;
    logic [2:0]             r_kw_cnt, n_kw_cnt;
    logic                   r_kw_miss, n_kw_miss;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [COLUMN_BITS-1:0] r_tcol, n_tcol;
    logic                   r_swallow, n_swallow;
    logic                   r_halted, n_halted;

    // result queue
    ast_pkg::t_token        r_q [ast_pkg::MAX_RES];
    ast_pkg::t_token        n_q [ast_pkg::MAX_RES];
    logic [1:0]             r_cnt, n_cnt;

    ast_pkg::t_token        res [ast_pkg::MAX_RES];
    logic [1:0]             nres;

    logic                   accept, pop;
    logic [7:0]             b;
    logic                   eot;

    assign b      = i_text.data.text_byte;
    assign eot    = i_text.data.end_of_text;
    assign pop    = o_token.valid && o_token.ready;
    assign i_text.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_token.ready);
    assign accept = i_text.valid && i_text.ready;
    assign o_token.valid = (r_cnt != 2'd0);
    assign o_token.data  = r_q[0];

    function automatic logic [15:0] f_line(input logic [LINE_BITS-1:0] v);
        return 16'(v);
    endfunction

    function automatic logic [11:0] f_col(input logic [COLUMN_BITS-1:0] v);
        return 12'(v);
    endfunction

    always_comb begin
        logic                  is_alpha, is_dig, eol, stop, idle, do_flush, str_byte;
        logic                  esc_out, kw_ok;
        logic [7:0]            esc_val;
        logic [4:0]            hx;
        logic [4:0]            dg;
        logic [1:0]            eff_base;
        logic [4:0]            pk;
        logic [VB+4:0]         prod;
        logic [LINE_BITS-1:0]  eof_line;
        n_mode = r_mode; n_base = r_base; n_acc = r_acc; n_quote = r_quote;
        n_esc = r_esc; n_esc_cnt = r_esc_cnt; n_kw_cnt = r_kw_cnt;
        n_kw_miss = r_kw_miss; n_line = r_line; n_col = r_col; n_tcol = r_tcol;
        n_swallow = r_swallow; n_halted = r_halted;
        for (int i = 0; i < ast_pkg::MAX_RES; i++) res[i] = '0;
        nres = 2'd0;
        stop = 1'b0; idle = 1'b0; do_flush = 1'b0; str_byte = 1'b0;
        esc_out = 1'b0; esc_val = 8'd0; dg = 5'h10; eff_base = r_base;
        pk = 5'd0; prod = '0;
        is_alpha = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
        is_dig   = (b >= 8'h30 && b <= 8'h39);
        eol      = (b == 8'h0a) || (b == 8'h0d);
        hx       = ast_pkg::f_hex(b);
        kw_ok    = !r_kw_miss && r_kw_cnt == 3'd5;
        eof_line = (r_line < LINE_TOP) ? r_line + 1'b1 : LINE_TOP;

        if (accept && !r_halted) begin
            if (eot) begin
                if (r_mode == ast_pkg::M_STRING || r_mode == ast_pkg::M_ESCAPE ||
                    r_mode == ast_pkg::M_ESC_OCT || r_mode == ast_pkg::M_ESC_HEX) begin
                    res[0].error_code    = ast_pkg::E_UNTERM;
                    res[0].line_number   = f_line(r_line);
                    res[0].column_number = f_col(r_col);
                    nres = 2'd1;
                    n_halted = 1'b1;
                end else begin
                    case (r_mode)
                        ast_pkg::M_SLASH:  begin pk = ast_pkg::K_DIV; nres = 2'd1; end
                        ast_pkg::M_ZERO:   begin pk = ast_pkg::K_INT; nres = 2'd1; end
                        ast_pkg::M_NUMBER: begin pk = ast_pkg::K_INT; nres = 2'd1; end
                        ast_pkg::M_IDENT:  begin
                            pk = kw_ok ? ast_pkg::K_TIMES : ast_pkg::K_IDENT; nres = 2'd1;
                        end
                        default: nres = 2'd0;
                    endcase
                    res[0].token_kind    = pk;
                    res[0].token_value   = (r_mode == ast_pkg::M_NUMBER) ? r_acc : '0;
                    res[0].line_number   = f_line(r_line);
                    res[0].column_number = f_col(r_tcol);
                    res[nres].token_kind    = ast_pkg::K_NEWLINE;
                    res[nres].line_number   = f_line(r_line);
                    res[nres].column_number = f_col(r_tcol);
                    res[nres+2'd1].token_kind  = ast_pkg::K_EOF;
                    res[nres+2'd1].line_number = f_line(eof_line);
                    nres = nres + 2'd2;
                    n_mode = ast_pkg::M_IDLE; n_base = 2'd0; n_acc = '0; n_quote = 1'b0;
                    n_esc = '0; n_esc_cnt = '0; n_kw_cnt = '0; n_kw_miss = 1'b0;
                    n_line = '0; n_col = '0; n_tcol = '0; n_swallow = 1'b0;
                end
            end else if (r_swallow && b == 8'h0a) begin
                n_swallow = 1'b0;
                stop = 1'b1;
            end else begin
                n_swallow = 1'b0;
                case (r_mode)
                    ast_pkg::M_COMMENT: idle = eol;
                    ast_pkg::M_SLASH: begin
                        if (b == 8'h2f) n_mode = ast_pkg::M_COMMENT;
                        else begin do_flush = 1'b1; idle = 1'b1; end
                    end
                    ast_pkg::M_ZERO, ast_pkg::M_NUMBER: begin
                        if (r_mode == ast_pkg::M_ZERO && (b == 8'h62 || b == 8'h78)) begin
                            n_mode = ast_pkg::M_NUMBER;
                            n_acc  = '0;
                            n_base = (b == 8'h62) ? ast_pkg::B_BIN : ast_pkg::B_HEX;
                        end else begin
                            if (r_mode == ast_pkg::M_ZERO) eff_base = ast_pkg::B_OCT;
                            case (eff_base)
                                ast_pkg::B_BIN: dg = (b == 8'h30 || b == 8'h31) ?
                                                     {4'd0, b[0]} : 5'h10;
                                ast_pkg::B_OCT: dg = (b >= 8'h30 && b <= 8'h37) ?
                                                     {2'd0, b[2:0]} : 5'h10;
                                ast_pkg::B_DEC: dg = is_dig ? {1'b0, hx[3:0]} : 5'h10;
                                default:        dg = hx;
                            endcase
                            if (!dg[4]) begin
                                logic [VB-1:0] a;
                                a = (r_mode == ast_pkg::M_ZERO) ? '0 : r_acc;
                                n_mode = ast_pkg::M_NUMBER;
                                n_base = eff_base;
                                case (eff_base)
                                    ast_pkg::B_BIN: prod = {4'd0, a, 1'b0};
                                    ast_pkg::B_OCT: prod = {2'd0, a, 3'd0};
                                    ast_pkg::B_DEC: prod = {2'd0, a, 3'd0} + {4'd0, a, 1'b0};
                                    default:        prod = {1'b0, a, 4'd0};
                                endcase
                                prod = prod + (VB+5)'(dg[3:0]);
                                n_acc = (prod > (VB+5)'(ast_pkg::VALUE_MAX)) ?
                                        ast_pkg::VALUE_MAX : prod[VB-1:0];
                            end else begin
                                do_flush = 1'b1; idle = 1'b1;
                            end
                        end
                    end
                    ast_pkg::M_IDENT: begin
                        if (is_alpha || is_dig) begin
                            if (!r_kw_miss && r_kw_cnt < 3'd5 &&
                                b == ast_pkg::f_times_char(r_kw_cnt))
                                n_kw_cnt = r_kw_cnt + 3'd1;
                            else n_kw_miss = 1'b1;
                            res[0].token_kind    = ast_pkg::K_IDENT;
                            res[0].is_text_byte  = 1'b1;
                            res[0].token_value   = VB'(b);
                            res[0].line_number   = f_line(r_line);
                            res[0].column_number = f_col(r_tcol);
                            nres = 2'd1;
                        end else begin
                            do_flush = 1'b1; idle = 1'b1;
                        end
                    end
                    ast_pkg::M_STRING: str_byte = 1'b1;
                    ast_pkg::M_ESCAPE: begin
                        if (eol) begin
                            res[0].error_code    = ast_pkg::E_UNTERM;
                            res[0].line_number   = f_line(r_line);
                            res[0].column_number = f_col(r_col);
                            nres = 2'd1; n_halted = 1'b1;
                        end else if (b >= 8'h30 && b <= 8'h37) begin
                            n_mode = ast_pkg::M_ESC_OCT;
                            n_esc = {5'd0, b[2:0]};
                            n_esc_cnt = 2'd1;
                        end else if (b == 8'h78) begin
                            n_mode = ast_pkg::M_ESC_HEX;
                            n_esc = '0;
                        end else begin
                            esc_out = 1'b1; esc_val = ast_pkg::f_escape_named(b);
                            n_mode = ast_pkg::M_STRING;
                        end
                    end
                    ast_pkg::M_ESC_OCT: begin
                        if (b >= 8'h30 && b <= 8'h37) begin
                            n_esc = {r_esc[4:0], b[2:0]};
                            n_esc_cnt = r_esc_cnt + 2'd1;
                            if (r_esc_cnt >= 2'd2) begin
                                esc_out = 1'b1; esc_val = {r_esc[4:0], b[2:0]};
                                n_mode = ast_pkg::M_STRING;
                            end
                        end else begin
                            esc_out = 1'b1; esc_val = r_esc; str_byte = 1'b1;
                        end
                    end
                    ast_pkg::M_ESC_HEX: begin
                        if (!hx[4]) n_esc = {r_esc[3:0], hx[3:0]};
                        else begin
                            esc_out = 1'b1; esc_val = r_esc; str_byte = 1'b1;
                        end
                    end
                    default: idle = 1'b1;
                endcase

                if (esc_out) begin
                    res[0].token_kind    = ast_pkg::K_STRING;
                    res[0].is_text_byte  = 1'b1;
                    res[0].token_value   = VB'(esc_val);
                    res[0].line_number   = f_line(r_line);
                    res[0].column_number = f_col(r_tcol);
                    nres = 2'd1;
                end

                if (do_flush) begin
                    case (r_mode)
                        ast_pkg::M_SLASH: pk = ast_pkg::K_DIV;
                        ast_pkg::M_IDENT: pk = kw_ok ? ast_pkg::K_TIMES : ast_pkg::K_IDENT;
                        default:          pk = ast_pkg::K_INT;
                    endcase
                    res[0].token_kind    = pk;
                    res[0].token_value   = (r_mode == ast_pkg::M_NUMBER) ? r_acc : '0;
                    res[0].line_number   = f_line(r_line);
                    res[0].column_number = f_col(r_tcol);
                    nres = 2'd1;
                end

                if (str_byte) begin
                    n_mode = ast_pkg::M_STRING;
                    res[nres].line_number   = f_line(r_line);
                    res[nres].column_number = f_col(r_tcol);
                    if (eol) begin
                        res[nres].error_code    = ast_pkg::E_UNTERM;
                        res[nres].column_number = f_col(r_col);
                        nres = nres + 2'd1; n_halted = 1'b1;
                    end else if (b == (r_quote ? 8'h27 : 8'h22)) begin
                        res[nres].token_kind = ast_pkg::K_STRING;
                        nres = nres + 2'd1; n_mode = ast_pkg::M_IDLE;
                    end else if (b == 8'h5c) begin
                        n_mode = ast_pkg::M_ESCAPE;
                    end else begin
                        res[nres].token_kind   = ast_pkg::K_STRING;
                        res[nres].is_text_byte = 1'b1;
                        res[nres].token_value  = VB'(b);
                        nres = nres + 2'd1;
                    end
                end

                if (idle) begin
                    n_mode = ast_pkg::M_IDLE;
                    res[nres].line_number   = f_line(r_line);
                    res[nres].column_number = f_col(r_col);
                    if (eol) begin
                        res[nres].token_kind    = ast_pkg::K_NEWLINE;
                        res[nres].column_number = f_col(r_tcol);
                        nres = nres + 2'd1;
                        n_line = (r_line < LINE_TOP) ? r_line + 1'b1 : LINE_TOP;
                        n_col = '0; n_tcol = '0;
                        n_swallow = (b == 8'h0d);
                    end else begin
                        n_tcol = r_col;
                        if (b == 8'h3b || b == 8'h23) n_mode = ast_pkg::M_COMMENT;
                        else if (b == 8'h2f) n_mode = ast_pkg::M_SLASH;
                        else if (b == 8'h30) n_mode = ast_pkg::M_ZERO;
                        else if (is_dig) begin
                            n_mode = ast_pkg::M_NUMBER; n_base = ast_pkg::B_DEC;
                            n_acc = VB'(hx[3:0]);
                        end else if (is_alpha) begin
                            n_mode = ast_pkg::M_IDENT;
                            n_kw_cnt = (b == 8'h74) ? 3'd1 : 3'd0;
                            n_kw_miss = (b != 8'h74);
                            res[nres].token_kind   = ast_pkg::K_IDENT;
                            res[nres].is_text_byte = 1'b1;
                            res[nres].token_value  = VB'(b);
                            nres = nres + 2'd1;
                        end else if (b == 8'h22 || b == 8'h27) begin
                            n_mode = ast_pkg::M_STRING; n_quote = (b == 8'h27);
                        end else begin
                            case (b)
                                8'h28: pk = ast_pkg::K_LPAREN;
                                8'h29: pk = ast_pkg::K_RPAREN;
                                8'h5b: pk = ast_pkg::K_LBRACK;
                                8'h5d: pk = ast_pkg::K_RBRACK;
                                8'h3a: pk = ast_pkg::K_COLON;
                                8'h2c: pk = ast_pkg::K_COMMA;
                                8'h2b: pk = ast_pkg::K_PLUS;
                                8'h2d: pk = ast_pkg::K_MINUS;
                                8'h2a: pk = ast_pkg::K_STAR;
                                8'h25: pk = ast_pkg::K_PERCENT;
                                default: pk = ast_pkg::K_INT;
                            endcase
                            if (b == 8'h20 || b == 8'h09 || b == 8'h0b || b == 8'h0c) begin
                                pk = ast_pkg::K_INT;
                            end else if (pk == ast_pkg::K_INT) begin
                                res[nres].error_code = ast_pkg::E_UNEXPECT;
                                nres = nres + 2'd1; n_halted = 1'b1;
                            end else begin
                                res[nres].token_kind = pk;
                                nres = nres + 2'd1;
                            end
                        end
                    end
                end
                if (!eol && r_col < COL_TOP) n_col = r_col + 1'b1;
            end
            if (nres != 2'd0) res[nres-2'd1].last = 1'b1;
        end

        // Queue update: shift out a popped beat, then append new results.
        for (int i = 0; i < ast_pkg::MAX_RES; i++) begin
            n_q[i] = (pop && i < ast_pkg::MAX_RES - 1) ? r_q[i+1] : r_q[i];
        end
        n_cnt = r_cnt - {1'b0, pop};
        for (int i = 0; i < ast_pkg::MAX_RES; i++) begin
            if (2'(i) < nres) n_q[2'(i) + n_cnt] = res[i];
        end
        n_cnt = n_cnt + nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ast_pkg::M_IDLE; r_base <= '0; r_acc <= '0; r_quote <= 1'b0;
            r_esc <= '0; r_esc_cnt <= '0; r_kw_cnt <= '0; r_kw_miss <= 1'b0;
            r_line <= '0; r_col <= '0; r_tcol <= '0; r_swallow <= 1'b0;
            r_halted <= 1'b0; r_cnt <= '0;
        end else begin
            r_mode <= n_mode; r_base <= n_base; r_acc <= n_acc; r_quote <= n_quote;
            r_esc <= n_esc; r_esc_cnt <= n_esc_cnt; r_kw_cnt <= n_kw_cnt;
            r_kw_miss <= n_kw_miss; r_line <= n_line; r_col <= n_col; r_tcol <= n_tcol;
            r_swallow <= n_swallow; r_halted <= n_halted; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ast_pkg::MAX_RES; i++) r_q[i] <= n_q[i];
    end

    `AST_ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd3)
    `AST_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted)
    `AST_ASSERT_IMPLY(a_no_take_full, i_clk, i_rst_n, r_cnt >= 2'd2, !i_text.ready)
    `AST_ASSERT_IMPLY(a_err_last, i_clk, i_rst_n,
        o_token.valid && o_token.data.error_code != ast_pkg::E_NONE, o_token.data.last)

endmodule

FILE: sim/assembly_source_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Assembly source tokenizer testbench
// A short table of hand-written source bytes is followed by random lexemes
// (identifiers, numbers of every base, strings with escapes, comments,
// punctuation, line ends and end of text). Every accepted byte goes through
// a lexer model in this file, and each token beat is compared with it.
// The run ends with one deliberate error that halts the block.
// ---------------------------------------------------------------------------
module assembly_source_tokenizer_unit_tb;

    localparam int LINE_TOP   = 65535;
    localparam int COLUMN_TOP = 4095;
    localparam int CYCLE_LIMIT = 300000;
    localparam longint unsigned VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam string TIMES_WORD = "times";

    typedef struct {
        ast_pkg::t_text item;
        bit             chk;
        logic [4:0]     kind;
        logic [62:0]    val;
        logic [1:0]     err;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ast_stream_if #(.T(ast_pkg::t_text))  text_if ();
    ast_stream_if #(.T(ast_pkg::t_token)) token_if ();

    assembly_source_tokenizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_token (token_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Lexer model state
    logic [3:0]      mode;
    logic [1:0]      base;
    longint unsigned acc;
    bit              quote_single;
    logic [7:0]      esc_acc;
    int              esc_cnt;
    int              kw_cnt;
    bit              kw_miss;
    int              line_cnt;
    int              col_cnt;
    int              tok_col;
    bit              swallow_lf;
    bit              halted;
    int              n_step;

    ast_pkg::t_token tokens_due[$];
    t_row   rows[$];
    int     fails = 0;
    int     beats_checked = 0;
    int     bytes_sent = 0;
    int     cycles = 0;
    bit     quiet;

    function automatic void lex_reset();
        mode = ast_pkg::M_IDLE; base = ast_pkg::B_BIN; acc = 0; quote_single = 0;
        esc_acc = 0; esc_cnt = 0; kw_cnt = 0; kw_miss = 0;
        line_cnt = 0; col_cnt = 0; tok_col = 0; swallow_lf = 0; halted = 0;
    endfunction

    function automatic void put(logic [4:0] k, bit t, longint unsigned v, int ln, int c,
                                logic [1:0] e);
        ast_pkg::t_token r;
        if (n_step >= 3) return;
        r.token_kind = k;
        r.is_text_byte = t;
        r.token_value = v[62:0];
        r.line_number = ln[15:0];
        r.column_number = c[11:0];
        r.error_code = e;
        r.last = 1'b0;
        tokens_due.push_back(r);
        n_step++;
    endfunction

    function automatic void halt_with(logic [1:0] code, int c);
        put(ast_pkg::K_INT, 0, 0, line_cnt, c, code);
        halted = 1;
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (is_digit(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic int digit_of(logic [7:0] b);
        case (base)
            ast_pkg::B_BIN: return (b == "0" || b == "1") ? b - "0" : -1;
            ast_pkg::B_OCT: return (b >= "0" && b <= "7") ? b - "0" : -1;
            ast_pkg::B_DEC: return is_digit(b) ? b - "0" : -1;
            default:        return hex_val(b);
        endcase
    endfunction

    function automatic void kw_feed(logic [7:0] b);
        if (!kw_miss && kw_cnt < 5 && b == TIMES_WORD[kw_cnt]) kw_cnt++;
        else kw_miss = 1;
    endfunction

    function automatic void flush_open();
        case (mode)
            ast_pkg::M_SLASH:  put(ast_pkg::K_DIV, 0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
            ast_pkg::M_ZERO:   put(ast_pkg::K_INT, 0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
            ast_pkg::M_NUMBER: put(ast_pkg::K_INT, 0, acc, line_cnt, tok_col, ast_pkg::E_NONE);
            ast_pkg::M_IDENT:  put((!kw_miss && kw_cnt == 5) ? ast_pkg::K_TIMES : ast_pkg::K_IDENT,
                                   0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
            default: ;
        endcase
        mode = ast_pkg::M_IDLE;
    endfunction

    function automatic void start_lexeme(logic [7:0] b, int c);
        logic [4:0] k;
        mode = ast_pkg::M_IDLE;
        if (b == 8'd10 || b == 8'd13) begin
            put(ast_pkg::K_NEWLINE, 0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
            if (line_cnt < LINE_TOP) line_cnt++;
            col_cnt = 0;
            tok_col = 0;
            swallow_lf = (b == 8'd13);
            return;
        end
        tok_col = c;
        if (b == ";" || b == "#") begin mode = ast_pkg::M_COMMENT; return; end
        if (b == "/") begin mode = ast_pkg::M_SLASH; return; end
        if (b == "0") begin mode = ast_pkg::M_ZERO; return; end
        if (is_digit(b)) begin
            mode = ast_pkg::M_NUMBER; base = ast_pkg::B_DEC; acc = b - "0";
            return;
        end
        if (is_alpha(b)) begin
            mode = ast_pkg::M_IDENT; kw_cnt = 0; kw_miss = 0;
            kw_feed(b);
            put(ast_pkg::K_IDENT, 1, b, line_cnt, c, ast_pkg::E_NONE);
            return;
        end
        if (b == "\"" || b == "'") begin
            mode = ast_pkg::M_STRING; quote_single = (b == "'");
            return;
        end
        case (b)
            "(": k = ast_pkg::K_LPAREN;
            ")": k = ast_pkg::K_RPAREN;
            "[": k = ast_pkg::K_LBRACK;
            "]": k = ast_pkg::K_RBRACK;
            ":": k = ast_pkg::K_COLON;
            ",": k = ast_pkg::K_COMMA;
            "+": k = ast_pkg::K_PLUS;
            "-": k = ast_pkg::K_MINUS;
            "*": k = ast_pkg::K_STAR;
            "%": k = ast_pkg::K_PERCENT;
            " ", 8'd9, 8'd11, 8'd12: return;
            default: begin halt_with(ast_pkg::E_UNEXPECT, c); return; end
        endcase
        put(k, 0, 0, line_cnt, c, ast_pkg::E_NONE);
    endfunction

    function automatic void string_in(logic [7:0] b, int c);
        mode = ast_pkg::M_STRING;
        if (b == 8'd10 || b == 8'd13) begin halt_with(ast_pkg::E_UNTERM, c); return; end
        if (b == (quote_single ? "'" : "\"")) begin
            put(ast_pkg::K_STRING, 0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
            mode = ast_pkg::M_IDLE;
            return;
        end
        if (b == "\\") begin mode = ast_pkg::M_ESCAPE; return; end
        put(ast_pkg::K_STRING, 1, b, line_cnt, tok_col, ast_pkg::E_NONE);
    endfunction

    function automatic logic [7:0] named_escape(logic [7:0] b);
        case (b)
            "a": return 8'd7;
            "b": return 8'd8;
            "e": return 8'd27;
            "f": return 8'd12;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            "v": return 8'd11;
            default: return b;
        endcase
    endfunction

    function automatic void number_in(logic [7:0] b, int c);
        int d;
        longint unsigned r;
        d = digit_of(b);
        r = (base == ast_pkg::B_BIN) ? 2 : (base == ast_pkg::B_OCT) ? 8 :
            (base == ast_pkg::B_DEC) ? 10 : 16;
        if (d >= 0) begin
            if (acc > (VMAX - d) / r) acc = VMAX;
            else acc = acc * r + d;
        end else begin
            flush_open();
            start_lexeme(b, c);
        end
    endfunction

    // Works out the token beats caused by one accepted input beat.
    function automatic void lex_predict(ast_pkg::t_text it);
        logic [7:0] b;
        int c;
        bit eol;
        int d;
        n_step = 0;
        if (halted) return;
        if (it.end_of_text) begin
            if (mode inside {ast_pkg::M_STRING, ast_pkg::M_ESCAPE, ast_pkg::M_ESC_OCT,
                             ast_pkg::M_ESC_HEX}) begin
                halt_with(ast_pkg::E_UNTERM, col_cnt);
            end else begin
                flush_open();
                put(ast_pkg::K_NEWLINE, 0, 0, line_cnt, tok_col, ast_pkg::E_NONE);
                put(ast_pkg::K_EOF, 0, 0, line_cnt < LINE_TOP ? line_cnt + 1 : LINE_TOP, 0,
                    ast_pkg::E_NONE);
                lex_reset();
            end
            tokens_due[$].last = 1'b1;
            return;
        end
        b = it.text_byte;
        c = col_cnt;
        eol = (b == 8'd10 || b == 8'd13);
        if (swallow_lf) begin
            swallow_lf = 0;
            if (b == 8'd10) return;
        end
        case (mode)
            ast_pkg::M_COMMENT: if (eol) start_lexeme(b, c);
            ast_pkg::M_SLASH: begin
                if (b == "/") mode = ast_pkg::M_COMMENT;
                else begin flush_open(); start_lexeme(b, c); end
            end
            ast_pkg::M_ZERO: begin
                mode = ast_pkg::M_NUMBER;
                acc = 0;
                if (b == "b") base = ast_pkg::B_BIN;
                else if (b == "x") base = ast_pkg::B_HEX;
                else begin base = ast_pkg::B_OCT; number_in(b, c); end
            end
            ast_pkg::M_NUMBER: number_in(b, c);
            ast_pkg::M_IDENT: begin
                if (is_alpha(b) || is_digit(b)) begin
                    kw_feed(b);
                    put(ast_pkg::K_IDENT, 1, b, line_cnt, tok_col, ast_pkg::E_NONE);
                end else begin
                    flush_open();
                    start_lexeme(b, c);
                end
            end
            ast_pkg::M_STRING: string_in(b, c);
            ast_pkg::M_ESCAPE: begin
                if (eol) halt_with(ast_pkg::E_UNTERM, c);
                else if (b >= "0" && b <= "7") begin
                    mode = ast_pkg::M_ESC_OCT; esc_acc = b - "0"; esc_cnt = 1;
                end else if (b == "x") begin
                    mode = ast_pkg::M_ESC_HEX; esc_acc = 0;
                end else begin
                    put(ast_pkg::K_STRING, 1, named_escape(b), line_cnt, tok_col,
                        ast_pkg::E_NONE);
                    mode = ast_pkg::M_STRING;
                end
            end
            ast_pkg::M_ESC_OCT: begin
                if (b >= "0" && b <= "7") begin
                    esc_acc = {esc_acc[4:0], 3'(b - "0")};
                    esc_cnt++;
                    if (esc_cnt >= 3) begin
                        put(ast_pkg::K_STRING, 1, esc_acc, line_cnt, tok_col, ast_pkg::E_NONE);
                        mode = ast_pkg::M_STRING;
                    end
                end else begin
                    put(ast_pkg::K_STRING, 1, esc_acc, line_cnt, tok_col, ast_pkg::E_NONE);
                    string_in(b, c);
                end
            end
            ast_pkg::M_ESC_HEX: begin
                d = hex_val(b);
                if (d >= 0) esc_acc = {esc_acc[3:0], 4'(d)};
                else begin
                    put(ast_pkg::K_STRING, 1, esc_acc, line_cnt, tok_col, ast_pkg::E_NONE);
                    string_in(b, c);
                end
            end
            default: start_lexeme(b, c);
        endcase
        if (!eol && col_cnt < COLUMN_TOP) col_cnt++;
        if (n_step > 0) tokens_due[$].last = 1'b1;
    endfunction

    // Stimulus building
    function automatic void add(logic [7:0] b, bit eot = 0);
        t_row r;
        r.item.text_byte = b;
        r.item.end_of_text = eot;
        r.chk = 0; r.kind = ast_pkg::K_INT; r.val = 0; r.err = ast_pkg::E_NONE;
        rows.push_back(r);
    endfunction

    function automatic void add_chk(logic [7:0] b, bit eot, logic [4:0] k, logic [62:0] v,
                                    logic [1:0] e = ast_pkg::E_NONE);
        t_row r;
        r.item.text_byte = b;
        r.item.end_of_text = eot;
        r.chk = 1; r.kind = k; r.val = v; r.err = e;
        rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] rand_content(bit in_string, logic [7:0] q);
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == 8'd10 || b == 8'd13 || (in_string && (b == q || b == "\\")));
        return b;
    endfunction

    function automatic void add_word(string s);
        foreach (s[i]) add(s[i]);
    endfunction

    // One random lexeme, always well formed so the block keeps running.
    function automatic void add_lexeme();
        int n;
        logic [7:0] q;
        string pun;
        string words[4];
        pun = "()[]:,+-*%/";
        words = '{"times", "time", "timesx", "Times"};
        case ($urandom_range(0, 13))
            0: begin
                add(rand_alpha());
                n = $urandom_range(0, 5);
                repeat (n) add($urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9))
                                                         : rand_alpha());
            end
            1: add_word(words[$urandom_range(0, 3)]);
            2: begin
                add(8'("1" + $urandom_range(0, 8)));
                n = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(17, 24);
                repeat (n) add(8'("0" + $urandom_range(0, 9)));
            end
            3: begin
                add_word("0x");
                n = $urandom_range(0, 3) == 0 ? $urandom_range(15, 19) : $urandom_range(0, 4);
                repeat (n) add(rand_hex());
            end
            4: begin
                add_word("0b");
                n = $urandom_range(0, 3) == 0 ? $urandom_range(60, 66) : $urandom_range(0, 8);
                repeat (n) add(8'("0" + $urandom_range(0, 1)));
            end
            5: begin
                add("0");
                n = $urandom_range(0, 3) == 0 ? $urandom_range(20, 23) : $urandom_range(0, 4);
                repeat (n) add(8'("0" + $urandom_range(0, 7)));
            end
            6: add(pun[$urandom_range(0, pun.len() - 1)]);
            7: begin
                case ($urandom_range(0, 3))
                    0: add(" ");
                    1: add(8'd9);
                    2: add(8'd11);
                    default: add(8'd12);
                endcase
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: add(8'd10);
                    1: add(8'd13);
                    default: begin add(8'd13); add(8'd10); end
                endcase
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: add(";");
                    1: add("#");
                    default: add_word("//");
                endcase
                n = $urandom_range(0, 10);
                repeat (n) add(rand_content(0, 0));
                add($urandom_range(0, 1) ? 8'd10 : 8'd13);
            end
            10, 11: begin
                q = $urandom_range(0, 1) ? "'" : "\"";
                add(q);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 2) != 0) add(rand_content(1, q));
                    else begin
                        add("\\");
                        case ($urandom_range(0, 3))
                            0: begin
                                pun = "abefnrtv";
                                add(pun[$urandom_range(0, 7)]);
                            end
                            1: add(rand_content(0, 0));
                            2: repeat ($urandom_range(1, 3)) add(8'("0" + $urandom_range(0, 7)));
                            default: begin
                                add("x");
                                repeat ($urandom_range(0, 3)) add(rand_hex());
                            end
                        endcase
                    end
                end
                add(q);
            end
            12: add(8'($urandom), 1);
            default: add(" ");
        endcase
    endfunction

    // Token side: random back-pressure and the comparison of every beat.
    initial token_if.ready = 1'b0;

    always @(posedge i_clk) begin
        ast_pkg::t_token want;
        ast_pkg::t_token got;
        cycles <= cycles + 1;
        token_if.ready <= i_rst_n && (quiet || $urandom_range(0, 99) >= 12);
        if (i_rst_n && token_if.valid && token_if.ready) begin
            got = token_if.data;
            beats_checked <= beats_checked + 1;
            if (tokens_due.size() == 0) begin
                $display("%0t: token beat with none expected, actual %p", $time, got);
                fails++;
            end else begin
                want = tokens_due.pop_front();
                if (got.token_kind !== want.token_kind) begin
                    $display("%0t: token_kind expected %0d actual %0d", $time,
                             want.token_kind, got.token_kind);
                    fails++;
                end
                if (got.is_text_byte !== want.is_text_byte) begin
                    $display("%0t: is_text_byte expected %0d actual %0d", $time,
                             want.is_text_byte, got.is_text_byte);
                    fails++;
                end
                if (got.token_value !== want.token_value) begin
                    $display("%0t: token_value expected %0h actual %0h", $time,
                             want.token_value, got.token_value);
                    fails++;
                end
                if (got.line_number !== want.line_number) begin
                    $display("%0t: line_number expected %0d actual %0d", $time,
                             want.line_number, got.line_number);
                    fails++;
                end
                if (got.column_number !== want.column_number) begin
                    $display("%0t: column_number expected %0d actual %0d", $time,
                             want.column_number, got.column_number);
                    fails++;
                end
                if (got.error_code !== want.error_code) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.error_code, got.error_code);
                    fails++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                    fails++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // A stretch in the middle of the run has no idle cycles on either side.
    assign quiet = (cycles >= 200 && cycles < 400);

    initial begin
        int counted;
        int before_n;
        t_row r;
        text_if.valid = 1'b0;
        text_if.data = '0;
        lex_reset();

        // Directed source: punctuation, hex, identifier, a string escape,
        // a 0xFF content byte, comment, CR LF pair and a bare 0b prefix.
        add_chk("(", 0, ast_pkg::K_LPAREN, 0);
        add("0"); add("x"); add("F");
        add_chk(",", 0, ast_pkg::K_COMMA, 0);
        add_chk("-", 0, ast_pkg::K_MINUS, 0);
        add_chk("a", 0, ast_pkg::K_IDENT, "a");
        add_chk("1", 0, ast_pkg::K_IDENT, "1");
        add_chk(" ", 0, ast_pkg::K_IDENT, 0);
        add("\""); add("\\");
        add_chk("e", 0, ast_pkg::K_STRING, 27);
        add_chk(8'hFF, 0, ast_pkg::K_STRING, 255);
        add_chk("\"", 0, ast_pkg::K_STRING, 0);
        add(";"); add("x");
        add_chk(8'd13, 0, ast_pkg::K_NEWLINE, 0);
        add(8'd10);
        add("0"); add("b");
        add_chk(8'h00, 1, ast_pkg::K_EOF, 0);

        counted = 0;
        while (counted < 450) begin
            before_n = rows.size();
            add_lexeme();
            counted += rows.size() - before_n;
        end

        // Finish with an error; the block then stays silent.
        add(8'd10);
        if ($urandom_range(0, 1)) begin
            add_chk("@", 0, ast_pkg::K_INT, 0, ast_pkg::E_UNEXPECT);
        end else begin
            add("\""); add("a");
            add_chk(8'd10, 0, ast_pkg::K_INT, 0, ast_pkg::E_UNTERM);
        end
        add("z");
        add(8'h00, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            while (!quiet && $urandom_range(0, 99) < 12) begin
                text_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            text_if.valid <= 1'b1;
            text_if.data <= r.item;
            @(posedge i_clk);
            while (!text_if.ready) @(posedge i_clk);
            before_n = tokens_due.size();
            lex_predict(r.item);
            bytes_sent++;
            if (r.chk) begin
                if (tokens_due.size() == before_n) begin
                    $display("%0t: row %0d expected kind %0d, model gives no beat",
                             $time, i, r.kind);
                    fails++;
                end else if (tokens_due[$].token_kind !== r.kind ||
                             tokens_due[$].token_value !== r.val ||
                             tokens_due[$].error_code !== r.err) begin
                    $display("%0t: row %0d expected kind %0d value %0h err %0d, actual %0d %0h %0d",
                             $time, i, r.kind, r.val, r.err, tokens_due[$].token_kind,
                             tokens_due[$].token_value, tokens_due[$].error_code);
                    fails++;
                end
            end
        end
        text_if.valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d input beats of directed and random source text, checked %0d token beats.",
                 bytes_sent, beats_checked);
        $display("Covered all number bases with saturation, string escapes, comments and an error halt.");
        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
